// ----- design/bbad_pkg.sv -----
// Shared types and constants for the banked bus address decoder.
// No dependencies; bbad_if, bbad_decode and the top level import this package.
`default_nettype none

package bbad_pkg;

	localparam int BANK_W     = 9;
	localparam int EXT_ADDR_W = 24;

	typedef enum logic [1:0] {
		FUNC_SND_RD  = 2'd0,
		FUNC_SND_WR  = 2'd1,
		FUNC_MAIN_RD = 2'd2,
		FUNC_MAIN_WR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		TGT_INTERNAL = 2'd0,
		TGT_FM       = 2'd1,
		TGT_MAIN     = 2'd2,
		TGT_PSG      = 2'd3
	} target_t;

	localparam logic [7:0]  PAGE_BANK     = 8'h60;
	localparam logic [7:0]  PAGE_MAIN_IO  = 8'h7F;
	localparam logic [15:0] MAIN_IO_BASE  = 16'hC000;
	localparam logic [4:0]  PSG_SLOT      = 5'b00010;   // low byte 0x10..0x17
	localparam logic [7:0]  UNMAPPED_DATA = 8'hFF;

	// Decoded access: control for the RAM and bank register plus the response fields
	typedef struct packed {
		logic                    ram_re;
		logic                    ram_we;
		logic                    bank_we;
		logic [7:0]              read_data;
		target_t                 target;
		logic [EXT_ADDR_W-1:0]   ext_address;
		logic [7:0]              ext_data;
		logic                    ext_is_write;
	} dec_t;

endpackage

`default_nettype wire

// ----- design/bbad_if.sv -----
// Valid/ready channel interfaces for bus access requests and responses.
// Depends on bbad_pkg for field types.
`default_nettype none

interface bbad_req_if
	import bbad_pkg::*;
();
	logic        valid;
	logic        ready;
	func_t       func;
	logic [15:0] bus_address;
	logic [7:0]  write_data;

	modport source (output valid, func, bus_address, write_data, input ready);
	modport sink   (input valid, func, bus_address, write_data, output ready);
endinterface

interface bbad_rsp_if
	import bbad_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [7:0]            read_data;
	target_t               target;
	logic [EXT_ADDR_W-1:0] ext_address;
	logic [7:0]            ext_data;
	logic                  ext_is_write;

	modport source (output valid, read_data, target, ext_address, ext_data, ext_is_write,
		input ready);
	modport sink   (input valid, read_data, target, ext_address, ext_data, ext_is_write,
		output ready);
endinterface

`default_nettype wire

// ----- design/bbad_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No package dependencies.
`default_nettype none

module bbad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/bbad_decode.sv -----
// Address map decode for one bus access.
// Depends on bbad_pkg (dec_t, codes and page constants).
`default_nettype none

module bbad_decode
	import bbad_pkg::*;
(
	input  wire func_t              func,
	input  wire logic [15:0]        bus_address,
	input  wire logic [7:0]         write_data,
	input  wire logic [BANK_W-1:0]  bank,
	output dec_t                    dec
);

	logic                  is_ram_win;
	logic                  is_fm_win;
	logic                  is_bank_page;
	logic                  is_io_page;
	logic                  is_banked;
	logic [EXT_ADDR_W-1:0] io_address;
	logic [EXT_ADDR_W-1:0] banked_address;
	logic [EXT_ADDR_W-1:0] fm_address;

	assign is_ram_win     = bus_address[15:14] == 2'b00;
	assign is_fm_win      = bus_address[15:13] == 3'b010;
	assign is_bank_page   = bus_address[15:8] == PAGE_BANK;
	assign is_io_page     = bus_address[15:8] == PAGE_MAIN_IO;
	assign is_banked      = bus_address[15];
	assign io_address     = {MAIN_IO_BASE, bus_address[7:0]};
	// bank << 15 plus a 15-bit offset never carries: plain concatenation
	assign banked_address = {bank, bus_address[14:0]};
	assign fm_address     = {{(EXT_ADDR_W-2){1'b0}}, bus_address[1:0]};

	always_comb begin
		dec              = '0;
		dec.target       = TGT_INTERNAL;
		unique case (func)
			FUNC_MAIN_RD: begin
				dec.ram_re = 1'b1;
			end
			FUNC_MAIN_WR: begin
				dec.ram_we = 1'b1;
			end
			FUNC_SND_RD: begin
				if (is_ram_win) begin
					dec.ram_re = 1'b1;
				end else if (is_fm_win) begin
					dec.target      = TGT_FM;
					dec.ext_address = fm_address;
				end else if (is_io_page) begin
					dec.target      = TGT_MAIN;
					dec.ext_address = io_address;
				end else if (is_banked) begin
					dec.target      = TGT_MAIN;
					dec.ext_address = banked_address;
				end else begin
					dec.read_data = UNMAPPED_DATA;
				end
			end
			FUNC_SND_WR: begin
				if (is_ram_win) begin
					dec.ram_we = 1'b1;
				end else if (is_fm_win) begin
					dec.target       = TGT_FM;
					dec.ext_address  = fm_address;
					dec.ext_data     = write_data;
					dec.ext_is_write = 1'b1;
				end else if (is_bank_page) begin
					dec.bank_we = 1'b1;
				end else if (is_io_page) begin
					// odd low byte in 0x11..0x17 goes to the PSG
					dec.target       = (bus_address[7:3] == PSG_SLOT && bus_address[0])
						? TGT_PSG : TGT_MAIN;
					dec.ext_address  = io_address;
					dec.ext_data     = write_data;
					dec.ext_is_write = 1'b1;
				end else if (is_banked) begin
					dec.target       = TGT_MAIN;
					dec.ext_address  = banked_address;
					dec.ext_data     = write_data;
					dec.ext_is_write = 1'b1;
				end
			end
			default: begin
				dec = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/banked_bus_address_decoder_unit.sv -----
// Top level of the banked bus address decoder: shared RAM, bank register, response pipe.
// Depends on bbad_pkg, bbad_if, bbad_ram and bbad_decode.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req     | in  | func, bus_address, write_data
//  rsp     | out | read_data, target, ext_address, ext_data, ext_is_write
//
// One access per cycle while rsp is not stalled; a request beat is registered in the
// RAM read stage, then in the output register, which drives rsp.valid.
// After reset every RAM address is swept to zero, with req.ready low.
// The RAM port is the only shared resource; one access per cycle means no conflicts.
// A stalled rsp holds the read stage; req keeps flowing while that stage is free.
`default_nettype none

module banked_bus_address_decoder_unit
	import bbad_pkg::*;
#(
	parameter int RAM_ADDR_BITS = 13
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bbad_req_if.sink   req,
	bbad_rsp_if.source rsp
);

	localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

	dec_t                     dec;
	logic [BANK_W-1:0]        bank_q;
	logic                     clr_q;
	logic [RAM_ADDR_BITS-1:0] clr_addr_q;
	logic                     acc;
	logic                     adv;

	logic                     ram_we;
	logic                     ram_re;
	logic [RAM_ADDR_BITS-1:0] ram_addr;
	logic [7:0]               ram_wdata;
	logic [7:0]               ram_rdata;

	// read stage
	logic                     v_s1;
	logic                     use_ram_s1;
	dec_t                     dec_s1;

	// output register
	logic                     out_v_q;
	logic [7:0]               read_data_q;
	target_t                  target_q;
	logic [EXT_ADDR_W-1:0]    ext_address_q;
	logic [7:0]               ext_data_q;
	logic                     ext_is_write_q;

	bbad_decode u_decode (
		.func        (req.func),
		.bus_address (req.bus_address),
		.write_data  (req.write_data),
		.bank        (bank_q),
		.dec         (dec)
	);

	assign adv       = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !clr_q && (!v_s1 || adv);
	assign acc       = req.valid && req.ready;

	assign ram_we    = clr_q || (acc && dec.ram_we);
	assign ram_re    = acc && dec.ram_re;
	assign ram_addr  = clr_q ? clr_addr_q : req.bus_address[RAM_ADDR_BITS-1:0];
	assign ram_wdata = clr_q ? 8'h00 : req.write_data;

	bbad_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// clearing sweep and bank shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			bank_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + RAM_ADDR_BITS'(1);
				if (&clr_addr_q) begin
					clr_q <= 1'b0;
				end
			end
			if (acc && dec.bank_we) begin
				bank_q <= {req.write_data[0], bank_q[BANK_W-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1     <= dec;
			use_ram_s1 <= dec.ram_re;
		end
		if (adv) begin
			// RAM read data holds while the read stage stalls: no new read is issued
			read_data_q    <= use_ram_s1 ? ram_rdata : dec_s1.read_data;
			target_q       <= dec_s1.target;
			ext_address_q  <= dec_s1.ext_address;
			ext_data_q     <= dec_s1.ext_data;
			ext_is_write_q <= dec_s1.ext_is_write;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.read_data    = read_data_q;
	assign rsp.target       = target_q;
	assign rsp.ext_address  = ext_address_q;
	assign rsp.ext_data     = ext_data_q;
	assign rsp.ext_is_write = ext_is_write_q;

endmodule

`default_nettype wire
